FILE: rtl/core/hbv_pkg.sv
// Shared types, register indexes and constant functions for the viscosity unit.
package hbv_pkg;

	// Register indexes on the configuration port (byte address / 4)
	localparam logic [1:0] REG_CONSISTENCY = 2'd0;
	localparam logic [1:0] REG_FLOW_INDEX  = 2'd1;
	localparam logic [1:0] REG_YIELD       = 2'd2;

	localparam logic [15:0] FLOW_INDEX_RESET = 16'd16384;

	// Output code width; results saturate at its largest code
	localparam int DATA_WIDTH = 32;

	// Fraction bits of the log and exp stages
	localparam int FRAC_BITS = 30;

	// Cycles from an accepted request to its result strobe
	localparam int HBV_LATENCY = 99;

	// Request data that rides along the pipeline
	typedef struct packed {
		logic [31:0] rate;
		logic [31:0] nu0;
		logic        rzero;
	} hbv_side_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [31:0] consistency;
		logic [15:0] flow_index;
		logic [31:0] yield_stress;
	} hbv_cfg_t;

	// Truncating integer square root, elaboration only
	function automatic logic [63:0] hbv_isqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] xv;
		xv    = x;
		res   = '0;
		bit_v = 64'h4000_0000_0000_0000;
		while (bit_v > xv)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (xv >= res + bit_v) begin
				xv  = xv - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// 2^(2^-idx) in Q1.31, built by repeated square roots from 2.0
	function automatic logic [31:0] hbv_exp2_coef(input int idx);
		logic [63:0] c;
		c = 64'h1_0000_0000;
		for (int j = 1; j <= idx; j++)
			c = hbv_isqrt(c << 31);
		return c[31:0];
	endfunction

endpackage

FILE: rtl/core/herschel_bulkley_viscosity_unit.sv
// Herschel-Bulkley apparent viscosity unit: configuration registers and pipeline top.
// Pipeline from start to done: 31 log stages, 31 exp stages and 37 divide stages.
// Throughput: one request per cycle; busy stays low, every stage advances each cycle.
// The divider sets the depth: one quotient bit per stage over 32 stages.
// Reset (arst_n low) clears all valid bits and loads k = 0, n = 1.0, tau0 = 0.
// The receiver cannot stall; done pulses for one cycle with each result.
module herschel_bulkley_viscosity_unit import hbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] strain_rate,
	input  logic [31:0] ceiling_viscosity,
	output logic        done,
	output logic [31:0] viscosity,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	hbv_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.consistency  <= '0;
			cfg_q.flow_index   <= FLOW_INDEX_RESET;
			cfg_q.yield_stress <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_CONSISTENCY: cfg_q.consistency  <= pwdata;
				REG_FLOW_INDEX:  cfg_q.flow_index   <= pwdata[15:0];
				REG_YIELD:       cfg_q.yield_stress <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[3:2])
			REG_CONSISTENCY: prdata = cfg_q.consistency;
			REG_FLOW_INDEX:  prdata = {16'd0, cfg_q.flow_index};
			REG_YIELD:       prdata = cfg_q.yield_stress;
			default:         prdata = '0;
		endcase
	end

	logic               lg_valid;
	logic signed [35:0] lg_log;
	hbv_side_t          lg_side;
	logic               ex_valid;
	logic [31:0]        ex_mant;
	logic signed [7:0]  ex_yi;
	hbv_side_t          ex_side;

	hbv_log2 u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_rate   (strain_rate),
		.in_nu0    (ceiling_viscosity),
		.out_valid (lg_valid),
		.out_log   (lg_log),
		.out_side  (lg_side)
	);

	hbv_exp2 u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (lg_valid),
		.in_log    (lg_log),
		.in_side   (lg_side),
		.out_valid (ex_valid),
		.out_mant  (ex_mant),
		.out_yi    (ex_yi),
		.out_side  (ex_side)
	);

	hbv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (ex_valid),
		.in_mant   (ex_mant),
		.in_yi     (ex_yi),
		.in_side   (ex_side),
		.out_valid (done),
		.out_visc  (viscosity)
	);

endmodule

FILE: rtl/core/hbv_log2.sv
// Log2 pipeline: normalize, then one squaring step per stage for 30 fraction bits.
module hbv_log2 import hbv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [31:0]        in_rate,
	input  logic [31:0]        in_nu0,
	output logic               out_valid,
	output logic signed [35:0] out_log,
	output hbv_side_t          out_side
);

	localparam int NSTG = FRAC_BITS + 1;

	logic                 v_s   [NSTG];
	logic [31:0]          m_s   [NSTG];
	logic [4:0]           e_s   [NSTG];
	logic [FRAC_BITS-1:0] frac_s[NSTG];
	hbv_side_t            side_s[NSTG];

	logic [4:0]  lead;
	logic [31:0] norm;

	// Find the top set bit and left-justify the mantissa
	always_comb begin
		lead = '0;
		for (int b = 0; b < 32; b++)
			if (in_rate[b])
				lead = 5'(b);
		norm = in_rate << (5'd31 - lead);
	end

	// Hold the valid bits under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		m_s[0]    <= norm;
		e_s[0]    <= lead;
		frac_s[0] <= '0;
		side_s[0] <= '{rate: in_rate, nu0: in_nu0, rzero: (in_rate == '0)};
	end

	// Square the mantissa, take one fraction bit per stage
	for (genvar i = 1; i < NSTG; i++) begin : g_sq
		logic [63:0] sq;
		logic        hi;
		assign sq = m_s[i-1] * m_s[i-1];
		assign hi = sq[63];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			m_s[i]    <= hi ? sq[63:32] : sq[62:31];
			e_s[i]    <= e_s[i-1];
			frac_s[i] <= {frac_s[i-1][FRAC_BITS-2:0], hi};
			side_s[i] <= side_s[i-1];
		end
	end

	// Integer part is exponent minus 16, fraction below it
	assign out_valid = v_s[NSTG-1];
	assign out_log   = $signed({6'($signed({1'b0, e_s[NSTG-1]}) - 6'sd16), frac_s[NSTG-1]});
	assign out_side  = side_s[NSTG-1];

endmodule

FILE: rtl/core/hbv_exp2.sv
// Exponent pipeline: scale the log by n, then one conditional multiply per fraction bit.
module hbv_exp2 import hbv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  hbv_cfg_t           cfg,
	input  logic               in_valid,
	input  logic signed [35:0] in_log,
	input  hbv_side_t          in_side,
	output logic               out_valid,
	output logic [31:0]        out_mant,
	output logic signed [7:0]  out_yi,
	output hbv_side_t          out_side
);

	localparam int NSTG = FRAC_BITS + 1;

	logic                 v_s   [NSTG];
	logic [31:0]          m_s   [NSTG];
	logic [FRAC_BITS-1:0] f_s   [NSTG];
	logic signed [7:0]    yi_s  [NSTG];
	hbv_side_t            side_s[NSTG];

	logic signed [52:0] prod_y;
	logic [52:0]        biased;

	// Scale by n and split into integer and fraction, offset keeps it positive
	always_comb begin
		prod_y = $signed({1'b0, cfg.flow_index}) * in_log;
		biased = 53'(prod_y) + (53'd1 << 50);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		m_s[0]    <= 32'h8000_0000;
		f_s[0]    <= biased[43:14];
		yi_s[0]   <= $signed({1'b0, biased[50:44]}) - 8'sd64;
		side_s[0] <= in_side;
	end

	// Multiply in 2^(2^-i) where fraction bit i is set
	for (genvar i = 1; i < NSTG; i++) begin : g_mul
		localparam logic [31:0] COEF = hbv_exp2_coef(i);
		logic [63:0] prod;
		assign prod = m_s[i-1] * COEF;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			m_s[i]    <= f_s[i-1][FRAC_BITS-i] ? prod[62:31] : m_s[i-1];
			f_s[i]    <= f_s[i-1];
			yi_s[i]   <= yi_s[i-1];
			side_s[i] <= side_s[i-1];
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign out_mant  = m_s[NSTG-1];
	assign out_yi    = yi_s[NSTG-1];
	assign out_side  = side_s[NSTG-1];

endmodule

FILE: rtl/core/hbv_div.sv
// Numerator build, radix-2 divider and final clamp to the ceiling.
module hbv_div import hbv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hbv_cfg_t          cfg,
	input  logic              in_valid,
	input  logic [31:0]       in_mant,
	input  logic signed [7:0] in_yi,
	input  hbv_side_t         in_side,
	output logic              out_valid,
	output logic [31:0]       out_visc
);

	localparam logic [31:0] OUT_MAX = (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << DATA_WIDTH) - 64'd1);
	localparam int QB = 32;

	// Stage 1: k times the power mantissa
	logic              v_s1;
	logic [63:0]       term_s1;
	logic signed [7:0] yi_s1;
	hbv_side_t         side_s1;
	logic [31:0]       mant_sel;
	logic signed [7:0] yi_sel;

	always_comb begin
		mant_sel = in_mant;
		yi_sel   = in_yi;
		if (cfg.flow_index == '0) begin
			mant_sel = 32'h8000_0000;
			yi_sel   = '0;
		end else if (in_side.rzero) begin
			mant_sel = '0;
		end
	end

	// Stage 2: scale by 2^(yi-15), saturate on left overflow
	logic              v_s2;
	logic [63:0]       term_s2;
	hbv_side_t         side_s2;
	logic signed [7:0] sft;
	logic [6:0]        rsh;
	logic [6:0]        lsh;
	logic [63:0]       scaled;

	always_comb begin
		sft    = yi_s1 - 8'sd15;
		rsh    = 7'(-sft);
		lsh    = sft[6:0];
		scaled = term_s1;
		if (sft < 0) begin
			scaled = (rsh >= 7'd64) ? '0 : term_s1 >> rsh;
		end else if (sft > 0) begin
			if ((term_s1 >> (7'd64 - lsh)) != '0)
				scaled = '1;
			else
				scaled = term_s1 << lsh;
		end
	end

	// Stage 3: add the yield term, saturate at the top
	logic        v_s3;
	logic [63:0] num_s3;
	hbv_side_t   side_s3;
	logic [64:0] sum;

	assign sum = {1'b0, term_s2} + {17'd0, cfg.yield_stress, 16'd0};

	// Stage 4: divisor select and quotient overflow test
	logic [31:0] den;
	logic        ovf_in;

	assign den    = side_s3.rzero ? 32'd1 : side_s3.rate;
	assign ovf_in = num_s3[63:32] >= den;

	logic        v_d   [QB+1];
	logic [31:0] rem_d [QB+1];
	logic [31:0] low_d [QB+1];
	logic [31:0] quo_d [QB+1];
	logic [31:0] den_d [QB+1];
	logic        ovf_d [QB+1];
	logic [31:0] nu0_d [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_d[0]   <= 1'b0;
		end else begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_d[0]   <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		term_s1  <= cfg.consistency * mant_sel;
		yi_s1    <= yi_sel;
		side_s1  <= in_side;
		term_s2  <= scaled;
		side_s2  <= side_s1;
		num_s3   <= sum[64] ? '1 : sum[63:0];
		side_s3  <= side_s2;
		rem_d[0] <= num_s3[63:32];
		low_d[0] <= num_s3[31:0];
		quo_d[0] <= '0;
		den_d[0] <= den;
		ovf_d[0] <= ovf_in;
		nu0_d[0] <= side_s3.nu0;
	end

	// One restoring quotient bit per stage
	for (genvar i = 1; i <= QB; i++) begin : g_div
		logic [32:0] part;
		logic        take;
		assign part = {rem_d[i-1], low_d[i-1][31]};
		assign take = part >= {1'b0, den_d[i-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[i] <= 1'b0;
			end else begin
				v_d[i] <= v_d[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_d[i] <= take ? 32'(part - {1'b0, den_d[i-1]}) : part[31:0];
			low_d[i] <= {low_d[i-1][30:0], 1'b0};
			quo_d[i] <= {quo_d[i-1][30:0], take};
			den_d[i] <= den_d[i-1];
			ovf_d[i] <= ovf_d[i-1];
			nu0_d[i] <= nu0_d[i-1];
		end
	end

	// Final stage: saturate, clamp to the ceiling
	logic        v_fin_q;
	logic [31:0] visc_q;
	logic [31:0] q_sat;
	logic [31:0] q_cap;

	always_comb begin
		q_sat = ovf_d[QB] ? 32'hFFFF_FFFF : quo_d[QB];
		if (q_sat > OUT_MAX)
			q_sat = OUT_MAX;
		q_cap = (q_sat > nu0_d[QB]) ? nu0_d[QB] : q_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_fin_q <= 1'b0;
		end else begin
			v_fin_q <= v_d[QB];
		end
	end

	always_ff @(posedge clk) begin
		visc_q <= q_cap;
	end

	assign out_valid = v_fin_q;
	assign out_visc  = visc_q;

endmodule

FILE: rtl/core/hbv_checker.sv
// Port-level checker for the viscosity unit, bound to the top level.
module hbv_checker import hbv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] ceiling_viscosity,
	input logic        done,
	input logic [31:0] viscosity,
	input logic        pready
);

	logic [6:0] warm_q;
	logic       warm;

	// Count cycles since reset until the pipeline history is valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != 7'(HBV_LATENCY)) begin
			warm_q <= warm_q + 7'd1;
		end
	end

	assign warm = (warm_q == 7'(HBV_LATENCY));

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, HBV_LATENCY)))
		else $error("result strobe does not match request");

	a_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done) |-> (viscosity <= $past(ceiling_viscosity, HBV_LATENCY)))
		else $error("result exceeds ceiling");

endmodule

bind herschel_bulkley_viscosity_unit hbv_checker u_hbv_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.ceiling_viscosity (ceiling_viscosity),
	.done              (done),
	.viscosity         (viscosity),
	.pready            (pready)
);
